[sv/bpbcd_pkg.sv]
// ----------------------------------------------------------------------------
// bpbcd_pkg: shared definitions for the binary to packed BCD unit
// Widths, sequencer states, the control and status structs between the
// converter core and the top level, and the per-digit add-3 correction.
// ----------------------------------------------------------------------------
package bpbcd_pkg;

  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = 4;
  localparam int DIGITS    = 10;
  localparam int BCD_W     = 4 * DIGITS;
  localparam int PAIRS     = DIGITS / 2;
  localparam int MAX_BYTES = 8;
  localparam int INDEX_W   = 3;
  localparam int STEP_W    = 5;
  localparam int IN_W      = 40;
  localparam int OUT_W     = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } dabble_ctrl_t;

  typedef struct packed {
    logic last_step;
  } dabble_sts_t;

  // Adds 3 to every decimal digit that is 5 or more, so that the following
  // left shift carries correctly into the next digit.
  function automatic logic [BCD_W-1:0] dabble_adjust(input logic [BCD_W-1:0] d);
    logic [BCD_W-1:0] r;
    r = d;
    for (int i = 0; i < DIGITS; i++) begin
      if (d[4*i +: 4] >= 4'd5) begin
        r[4*i +: 4] = d[4*i +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

endpackage

[sv/bpbcd_dabble.sv]
// ----------------------------------------------------------------------------
// bpbcd_dabble: iterative shift-add-3 converter core
// Holds the binary shift register and the BCD accumulator. One correction
// and shift happens per step; a step counter flags the final step.
// ----------------------------------------------------------------------------
module bpbcd_dabble (
  input  logic                                  clk,
  input  logic                                  rst,
  input  bpbcd_pkg::dabble_ctrl_t               ctrl,
  input  logic [bpbcd_pkg::VALUE_W-1:0]         value,
  output bpbcd_pkg::dabble_sts_t                sts,
  output logic [bpbcd_pkg::BCD_W-1:0]           bcd
);

  logic [bpbcd_pkg::VALUE_W-1:0] bin;
  logic [bpbcd_pkg::STEP_W-1:0]  step_cnt;
  logic [bpbcd_pkg::BCD_W-1:0]   bcd_adj;

  assign bcd_adj = bpbcd_pkg::dabble_adjust(bcd);
  assign sts.last_step = (step_cnt == bpbcd_pkg::STEP_W'(bpbcd_pkg::VALUE_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (ctrl.load) begin
      step_cnt <= '0;
    end else if (ctrl.step) begin
      step_cnt <= step_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      bin <= value;
      bcd <= '0;
    end else if (ctrl.step) begin
      {bcd, bin} <= {bcd_adj[bpbcd_pkg::BCD_W-2:0], bin, 1'b0};
    end
  end

endmodule

[sv/binary_to_packed_bcd_unit.sv]
// ----------------------------------------------------------------------------
// binary_to_packed_bcd_unit: binary to packed BCD byte stream
// Converts a 32-bit unsigned value to decimal and streams it as packed BCD
// bytes, lowest or highest digit pair first.
// ----------------------------------------------------------------------------
// Each input beat carries a value, a byte count and an order flag. The count
// saturates at eight bytes and a count of zero produces no output. Pairs
// above the value's ten digits come out as 0x00 and digits that do not fit
// in the count are dropped. An accepted beat is loaded, taken through one
// shift-add-3 step per value bit in the single correction unit, and then
// emitted at one byte per cycle while the output is taken. The input is not
// ready while a conversion or its byte emission is running; the final byte
// may still wait in the output register while the next beat is accepted.
module binary_to_packed_bcd_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [31:0] value, [35:32] byte_count, [36] most_significant_first, [39:37] zero
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] bcd_byte, [10:8] byte_index, [15:11] zero
  output logic [15:0] m_tdata,
  // last
  output logic        m_tlast
);

  bpbcd_pkg::state_t                state, state_next;
  bpbcd_pkg::dabble_ctrl_t          ctrl;
  bpbcd_pkg::dabble_sts_t           sts;
  logic [bpbcd_pkg::BCD_W-1:0]      bcd;

  logic [bpbcd_pkg::COUNT_W-1:0]    count;
  logic                             msf;
  logic [bpbcd_pkg::INDEX_W-1:0]    index;

  logic                             in_accept;
  logic [bpbcd_pkg::COUNT_W-1:0]    in_count;
  logic [bpbcd_pkg::COUNT_W-1:0]    in_count_sat;
  logic                             load_out;
  logic                             out_last;
  logic [bpbcd_pkg::COUNT_W-1:0]    src_wide;
  logic [bpbcd_pkg::INDEX_W-1:0]    src;
  logic [7:0]                       pair_byte;

  assign in_accept    = s_tvalid && s_tready;
  assign in_count     = s_tdata[35:32];
  assign in_count_sat = (in_count > bpbcd_pkg::COUNT_W'(bpbcd_pkg::MAX_BYTES)) ?
                        bpbcd_pkg::COUNT_W'(bpbcd_pkg::MAX_BYTES) : in_count;

  bpbcd_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .value (s_tdata[31:0]),
    .sts   (sts),
    .bcd   (bcd)
  );

  // Most significant first reads the pairs from the top of the kept range down.
  assign out_last = ({1'b0, index} == (count - 1'b1));
  assign src_wide = msf ? (count - 1'b1 - {1'b0, index}) : {1'b0, index};
  assign src      = src_wide[bpbcd_pkg::INDEX_W-1:0];

  always_comb begin
    pair_byte = 8'h00;
    if (src < bpbcd_pkg::INDEX_W'(bpbcd_pkg::PAIRS)) begin
      pair_byte = bcd[{src, 3'b000} +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpbcd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ctrl.load  = 1'b0;
    ctrl.step  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      bpbcd_pkg::ST_IDLE: begin
        s_tready  = 1'b1;
        ctrl.load = s_tvalid;
        if (s_tvalid && (in_count != '0)) begin
          state_next = bpbcd_pkg::ST_CONVERT;
        end
      end
      bpbcd_pkg::ST_CONVERT: begin
        ctrl.step = 1'b1;
        if (sts.last_step) begin
          state_next = bpbcd_pkg::ST_EMIT;
        end
      end
      bpbcd_pkg::ST_EMIT: begin
        load_out = !m_tvalid || m_tready;
        if (load_out && out_last) begin
          state_next = bpbcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bpbcd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      count <= in_count_sat;
      msf   <= s_tdata[36];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index <= '0;
    end else if (in_accept) begin
      index <= '0;
    end else if (load_out) begin
      index <= index + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {5'b00000, index, pair_byte};
      m_tlast <= out_last;
    end
  end

  a_convert_to_emit: assert property (@(posedge clk) disable iff (rst)
    (state == bpbcd_pkg::ST_CONVERT && sts.last_step) |=> (state == bpbcd_pkg::ST_EMIT))
    else $error("conversion did not move on to emission after the final step");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (in_count != '0)) |=> (state == bpbcd_pkg::ST_CONVERT))
    else $error("accepted beat with nonzero count did not start a conversion");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (load_out && out_last) |=> (state == bpbcd_pkg::ST_IDLE && m_tvalid && m_tlast))
    else $error("final byte did not return the unit to idle");

  a_bcd_digits: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:4] <= 4'd9 && m_tdata[3:0] <= 4'd9))
    else $error("output byte holds a digit above nine");

endmodule
